### sv/cpr_pkg.sv
// ---------------------------------------------------------------------------
// cpr_pkg
// Shared types, constants and helper functions for the carpet pixel renderer.
// ---------------------------------------------------------------------------
package cpr_pkg;

   localparam int PANEL_SIDE   = 16;
   localparam int MAX_PANELS   = 4;
   localparam int PALETTE_MAX  = 256;
   localparam int DEPTH_MAX    = 6;
   localparam int SIDE_W       = $clog2(PANEL_SIDE);
   localparam int THIRD        = PANEL_SIDE / 3;
   localparam int HALF_SIDE    = PANEL_SIDE / 2;

   localparam int X_W          = 6;
   localparam int Y_W          = 4;
   localparam int LED_W        = 10;
   localparam int COLOR_W      = 8;
   localparam int DEPTH_W      = 3;
   localparam int ROTS_W       = 6;
   localparam int COUNT_W      = 3;
   localparam int PAL_W        = 9;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 9;

   // modulo unit: dividend bits, bits retired per step, step count
   localparam int DIV_W        = 9;
   localparam int DIV_RADIX_W  = 3;
   localparam int DIV_STEPS    = DIV_W / DIV_RADIX_W;
   localparam int STEP_CNT_W   = $clog2(DIV_STEPS);

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] REG_CARPET_DEPTH    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INVERT_PATTERN  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COLOR_SHIFT     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PANEL_REVERSE   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_PANEL_ROTATIONS = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_PANEL_COUNT     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_PALETTE_SIZE    = 3'd6;

   typedef struct packed {
      logic [DEPTH_W-1:0] carpet_depth;
      logic               invert_pattern;
      logic [COLOR_W-1:0] color_shift;
      logic               panel_reverse;
      logic [ROTS_W-1:0]  panel_rotations;
      logic [COUNT_W-1:0] panel_count;
      logic [PAL_W-1:0]   palette_size;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      carpet_depth:    3'd4,
      invert_pattern:  1'b0,
      color_shift:     8'd2,
      panel_reverse:   1'b0,
      panel_rotations: 6'd0,
      panel_count:     3'd1,
      palette_size:    9'd0
   };

   typedef struct packed {
      logic load;
      logic tick;
      logic step;
      logic emit;
   } cmd_type;

   function automatic logic [SIDE_W-1:0] mod_third(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      r = v;
      for (int i = 0; i < 3; i++) begin
         if (r >= SIDE_W'(THIRD)) r = r - SIDE_W'(THIRD);
      end
      return r;
   endfunction

   // two effective levels: span 16 -> third 5 -> third 1, then span too small
   function automatic logic is_hole(input logic [SIDE_W-1:0] x,
                                    input logic [SIDE_W-1:0] y,
                                    input logic [DEPTH_W-1:0] depth);
      logic l1;
      logic l2;
      l1 = (x >= SIDE_W'(THIRD)) && (x < SIDE_W'(2 * THIRD)) &&
           (y >= SIDE_W'(THIRD)) && (y < SIDE_W'(2 * THIRD));
      l2 = (depth >= DEPTH_W'(2)) && (mod_third(x) == SIDE_W'(1)) &&
           (mod_third(y) == SIDE_W'(1));
      return l1 || l2;
   endfunction

   // restoring remainder, DIV_RADIX_W dividend bits per call
   function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0]       rem,
                                                 input logic [DIV_RADIX_W-1:0] bits,
                                                 input logic [PAL_W-1:0]       dvs);
      logic [DIV_W:0]   t;
      logic [DIV_W-1:0] r;
      r = rem;
      for (int i = DIV_RADIX_W - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, dvs}) t = t - {1'b0, dvs};
         r = t[DIV_W-1:0];
      end
      return r;
   endfunction

endpackage

### sv/cpr_req_if.sv
// ---------------------------------------------------------------------------
// cpr_req_if
// Request channel: pixel coordinates or frame tick.
// ---------------------------------------------------------------------------
interface cpr_req_if import cpr_pkg::*;;
   logic             valid;
   logic             ready;
   logic             mode;
   logic [X_W-1:0]   pixel_x;
   logic [Y_W-1:0]   pixel_y;

   modport source (output valid, mode, pixel_x, pixel_y, input ready);
   modport sink   (input valid, mode, pixel_x, pixel_y, output ready);
endinterface

### sv/cpr_rsp_if.sv
// ---------------------------------------------------------------------------
// cpr_rsp_if
// Response channel: LED position and color of one pixel.
// ---------------------------------------------------------------------------
interface cpr_rsp_if import cpr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [LED_W-1:0]   led_index;
   logic               index_valid;
   logic               pixel_lit;
   logic               from_palette;
   logic [COLOR_W-1:0] color_value;

   modport source (output valid, led_index, index_valid, pixel_lit, from_palette,
                   color_value, input ready);
   modport sink   (input valid, led_index, index_valid, pixel_lit, from_palette,
                   color_value, output ready);
endinterface

### sv/cpr_csr_if.sv
// ---------------------------------------------------------------------------
// cpr_csr_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface cpr_csr_if import cpr_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/cpr_regs.sv
// ---------------------------------------------------------------------------
// cpr_regs
// Configuration register file, written one word per handshake.
// ---------------------------------------------------------------------------
module cpr_regs import cpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   output logic                  wr_ready,
   input  logic [CSR_ADDR_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            REG_CARPET_DEPTH:    cfg_in.carpet_depth    = wr_data[DEPTH_W-1:0];
            REG_INVERT_PATTERN:  cfg_in.invert_pattern  = wr_data[0];
            REG_COLOR_SHIFT:     cfg_in.color_shift     = wr_data[COLOR_W-1:0];
            REG_PANEL_REVERSE:   cfg_in.panel_reverse   = wr_data[0];
            REG_PANEL_ROTATIONS: cfg_in.panel_rotations = wr_data[ROTS_W-1:0];
            REG_PANEL_COUNT:     cfg_in.panel_count     = wr_data[COUNT_W-1:0];
            REG_PALETTE_SIZE:    cfg_in.palette_size    = wr_data[PAL_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/cpr_ctrl.sv
// ---------------------------------------------------------------------------
// cpr_ctrl
// Sequencer: on a tick word issues the tick command; on a pixel word runs the
// remainder steps, loads the result register and tracks its handshake.
// ---------------------------------------------------------------------------
module cpr_ctrl import cpr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_mode,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIV_STEPS - 1);

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_TICK) begin
                  cmd.tick = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  cnt_in   = '0;
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_pixel_starts_calc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_PIXEL) |=> (state_ff == S_CALC && cnt_ff == '0))
      else $error("pixel word did not start the remainder steps");

   a_calc_length: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_PIXEL) |-> ##DIV_STEPS
         (state_ff == S_CALC && cnt_ff == LAST_STEP))
      else $error("remainder steps ran the wrong number of cycles");

   a_tick_no_calc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_TICK) |=> (state_ff == S_IDLE && !cmd.step))
      else $error("tick word started a computation");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result loaded without valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");
`endif

endmodule

### sv/cpr_dp.sv
// ---------------------------------------------------------------------------
// cpr_dp
// Datapath: color phase, carpet test and LED mapping at load, three-step
// palette remainder, and the result register.
// ---------------------------------------------------------------------------
module cpr_dp import cpr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  cfg_type            cfg,
   input  logic [X_W-1:0]     pixel_x,
   input  logic [Y_W-1:0]     pixel_y,
   output logic [LED_W-1:0]   led_index,
   output logic               index_valid,
   output logic               pixel_lit,
   output logic               from_palette,
   output logic [COLOR_W-1:0] color_value
);

   localparam int PANEL_W = X_W - SIDE_W;

   logic [COLOR_W-1:0] phase_ff, phase_in;
   logic [DIV_W-1:0]   div_ff, rem_ff;
   logic [DIV_W-1:0]   rem_nx, rem_fin;
   logic               lit_ff, valid_ff;
   logic [COLOR_W-1:0] hue_ff;
   logic [LED_W-1:0]   led_ff;

   logic [LED_W-1:0]   rsp_led_ff;
   logic               rsp_valid_idx_ff, rsp_lit_ff, rsp_pal_ff;
   logic [COLOR_W-1:0] rsp_color_ff;

   logic [COUNT_W-1:0] panels;
   logic [PANEL_W-1:0] panel;
   logic               on_panel;
   logic [X_W:0]       off_x;
   logic               in_sq;
   logic [SIDE_W-1:0]  cx;
   logic               draw;
   logic               lit_c;
   logic [COLOR_W-1:0] hue_c;
   logic [DIV_W-1:0]   sum_c;
   logic [1:0]         rot;
   logic [SIDE_W-1:0]  lx, ly, lx0, ly0;
   logic [COUNT_W-1:0] eff;
   logic [LED_W-1:0]   led_c;
   logic [PAL_W-1:0]   pal;
   logic [COLOR_W-1:0] color_c;

   // ---- load-time mapping ----
   always_comb begin
      if (cfg.panel_count == '0) begin
         panels = COUNT_W'(1);
      end else if (cfg.panel_count > COUNT_W'(MAX_PANELS)) begin
         panels = COUNT_W'(MAX_PANELS);
      end else begin
         panels = cfg.panel_count;
      end
      panel    = pixel_x[X_W-1:SIDE_W];
      on_panel = COUNT_W'(panel) < panels;
      off_x    = (X_W+1)'((panels - 1'b1) * HALF_SIDE);
      in_sq    = ((X_W+1)'(pixel_x) >= off_x) &&
                 ((X_W+1)'(pixel_x) < off_x + (X_W+1)'(PANEL_SIDE));
      cx       = SIDE_W'((X_W+1)'(pixel_x) - off_x);
      draw     = cfg.invert_pattern ? is_hole(cx, pixel_y, cfg.carpet_depth)
                                    : !is_hole(cx, pixel_y, cfg.carpet_depth);
      lit_c    = on_panel && in_sq && draw;
      hue_c    = COLOR_W'(10'(cx) * 10'd4 + 10'(pixel_y) * 10'd3 + 10'(phase_ff));
      sum_c    = DIV_W'(cx) + DIV_W'(pixel_y) + DIV_W'(phase_ff);

      lx0 = pixel_x[SIDE_W-1:0];
      ly0 = pixel_y;
      if (COUNT_W'(panel) < COUNT_W'(3)) begin
         rot = cfg.panel_rotations[2*panel +: 2];
      end else begin
         rot = ROT_0;
      end
      case (rot)
         ROT_90: begin
            lx = ly0;
            ly = SIDE_W'(PANEL_SIDE - 1) - lx0;
         end
         ROT_180: begin
            lx = SIDE_W'(PANEL_SIDE - 1) - lx0;
            ly = SIDE_W'(PANEL_SIDE - 1) - ly0;
         end
         ROT_270: begin
            lx = SIDE_W'(PANEL_SIDE - 1) - ly0;
            ly = lx0;
         end
         default: begin
            lx = lx0;
            ly = ly0;
         end
      endcase
      if (ly[0]) lx = SIDE_W'(PANEL_SIDE - 1) - lx;

      eff   = cfg.panel_reverse ? (panels - 1'b1 - COUNT_W'(panel)) : COUNT_W'(panel);
      led_c = on_panel ? LED_W'({eff, ly, lx}) : '0;
   end

   // ---- remainder and result ----
   always_comb begin
      if (cfg.palette_size > PAL_W'(PALETTE_MAX)) begin
         pal = PAL_W'(PALETTE_MAX);
      end else begin
         pal = cfg.palette_size;
      end
      rem_nx  = rem_step(rem_ff, div_ff[DIV_W-1 -: DIV_RADIX_W], pal);
      rem_fin = cmd.step ? rem_nx : rem_ff;
      if (!lit_ff) begin
         color_c = '0;
      end else if (pal != '0) begin
         color_c = rem_fin[COLOR_W-1:0];
      end else begin
         color_c = hue_ff;
      end
      phase_in = cmd.tick ? (phase_ff + cfg.color_shift) : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         div_ff   <= sum_c;
         rem_ff   <= '0;
         lit_ff   <= lit_c;
         valid_ff <= on_panel;
         hue_ff   <= hue_c;
         led_ff   <= led_c;
      end else if (cmd.step) begin
         div_ff   <= div_ff << DIV_RADIX_W;
         rem_ff   <= rem_nx;
      end
      if (cmd.emit) begin
         rsp_led_ff       <= led_ff;
         rsp_valid_idx_ff <= valid_ff;
         rsp_lit_ff       <= lit_ff;
         rsp_pal_ff       <= (pal != '0);
         rsp_color_ff     <= color_c;
      end
   end

   assign led_index    = rsp_led_ff;
   assign index_valid  = rsp_valid_idx_ff;
   assign pixel_lit    = rsp_lit_ff;
   assign from_palette = rsp_pal_ff;
   assign color_value  = rsp_color_ff;

endmodule

### sv/carpet_pixel_render_panel_map.sv
// ---------------------------------------------------------------------------
// carpet_pixel_render_panel_map
// Carpet pattern pixel renderer with serpentine LED panel mapping.
// ---------------------------------------------------------------------------
// A tick word (mode 1) adds color_shift to the color phase in the cycle it is
// accepted and returns nothing. A pixel word (mode 0) returns one response word:
// a load step in the accepting cycle maps the coordinate and tests the carpet,
// then three steps of a radix-8 remainder unit compute the palette index; the
// last of those steps writes the response register. The next word is taken in
// the cycle after that; no new word is taken while a pixel is being computed.
// While a response is held by backpressure one more pixel word is taken and
// computed; its result then waits for the response register, and no new word
// is taken until that load happens.
module carpet_pixel_render_panel_map import cpr_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   cpr_req_if.sink   req_ch,
   cpr_rsp_if.source rsp_ch,
   cpr_csr_if.sink   csr_ch
);

   cfg_type cfg;
   cmd_type cmd;

   cpr_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_ready (csr_ch.ready),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   cpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   cpr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .pixel_x      (req_ch.pixel_x),
      .pixel_y      (req_ch.pixel_y),
      .led_index    (rsp_ch.led_index),
      .index_valid  (rsp_ch.index_valid),
      .pixel_lit    (rsp_ch.pixel_lit),
      .from_palette (rsp_ch.from_palette),
      .color_value  (rsp_ch.color_value)
   );

endmodule

### tb/cpr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpr_checker
// Watches the CSR, request and response channels of the carpet pixel
// renderer. Keeps its own copy of the registers and the color phase, predicts
// one response word per accepted pixel word and compares each response word,
// field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
module cpr_checker import cpr_pkg::*; (
   input  logic clock,
   input  logic reset,
   cpr_req_if   req_ch,
   cpr_rsp_if   rsp_ch,
   cpr_csr_if   csr_ch,
   output int   pending_cnt,
   output int   fail_count
);

   typedef struct packed {
      logic [LED_W-1:0]   led_index;
      logic               index_valid;
      logic               pixel_lit;
      logic               from_palette;
      logic [COLOR_W-1:0] color_value;
   } pixel_word_t;

   cfg_type            shadow_cfg = CFG_RESET;
   logic [COLOR_W-1:0] color_phase = '0;
   pixel_word_t        expected_words[$];
   int                 mismatch_count = 0;

   assign fail_count = mismatch_count;

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatch_count++;
      $display("mismatch %s: got %0d, predicted %0d", field, got, want);
   endtask

   function automatic logic carpet_hole(input int cx, input int cy, input int depth);
      int span;
      int third;
      span = PANEL_SIDE;
      for (int lvl = 0; lvl < depth; lvl++) begin
         if (span < 3) break;
         third = span / 3;
         if (cx / third == 1 && cy / third == 1) return 1'b1;
         cx = cx % third;
         cy = cy % third;
         span = third;
      end
      return 1'b0;
   endfunction

   function automatic pixel_word_t render_pixel(input logic [X_W-1:0] px,
                                                input logic [Y_W-1:0] py);
      pixel_word_t w;
      int x, y, phase, panels, width, off_x, depth, pal;
      int panel, lx, ly, cx, t, eff;
      logic [1:0] rot;
      w = '0;
      x = int'(px);
      y = int'(py);
      phase = int'(color_phase);
      panels = int'(shadow_cfg.panel_count);
      if (panels < 1) panels = 1;
      if (panels > MAX_PANELS) panels = MAX_PANELS;
      width = panels * PANEL_SIDE;
      off_x = (width - PANEL_SIDE) / 2;
      depth = int'(shadow_cfg.carpet_depth);
      if (depth < 1) depth = 1;
      if (depth > DEPTH_MAX) depth = DEPTH_MAX;
      pal = int'(shadow_cfg.palette_size);
      if (pal > PALETTE_MAX) pal = PALETTE_MAX;
      w.from_palette = (pal != 0);
      if (x < width) begin
         panel = x / PANEL_SIDE;
         lx = x % PANEL_SIDE;
         ly = y;
         if (x >= off_x && x < off_x + PANEL_SIDE) begin
            cx = x - off_x;
            // drawn when the hole test agrees with the inversion bit
            if (carpet_hole(cx, y, depth) == shadow_cfg.invert_pattern) begin
               w.pixel_lit = 1'b1;
               if (pal != 0)
                  w.color_value = COLOR_W'((cx + y + phase) % pal);
               else
                  w.color_value = COLOR_W'(cx * 4 + y * 3 + phase);
            end
         end
         rot = ROT_0;
         if (panel < 3) rot = shadow_cfg.panel_rotations[2 * panel +: 2];
         case (rot)
            ROT_90: begin
               t = ly;
               ly = PANEL_SIDE - 1 - lx;
               lx = t;
            end
            ROT_180: begin
               lx = PANEL_SIDE - 1 - lx;
               ly = PANEL_SIDE - 1 - ly;
            end
            ROT_270: begin
               t = PANEL_SIDE - 1 - ly;
               ly = lx;
               lx = t;
            end
            default: ;
         endcase
         if (ly % 2 == 1) lx = PANEL_SIDE - 1 - lx;
         eff = shadow_cfg.panel_reverse ? panels - 1 - panel : panel;
         w.led_index = LED_W'(eff * PANEL_SIDE * PANEL_SIDE + ly * PANEL_SIDE + lx);
         w.index_valid = 1'b1;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      pixel_word_t got;
      pixel_word_t want;
      if (reset) begin
         shadow_cfg = CFG_RESET;
         color_phase = '0;
         expected_words.delete();
      end else begin
         // response first: a word accepted this edge cannot answer a request taken now
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.led_index    = rsp_ch.led_index;
            got.index_valid  = rsp_ch.index_valid;
            got.pixel_lit    = rsp_ch.pixel_lit;
            got.from_palette = rsp_ch.from_palette;
            got.color_value  = rsp_ch.color_value;
            if (expected_words.size() == 0) begin
               report_mismatch("unrequested response word led_index", got.led_index, 0);
            end else begin
               want = expected_words.pop_front();
               if (got.led_index !== want.led_index)
                  report_mismatch("led_index", got.led_index, want.led_index);
               if (got.index_valid !== want.index_valid)
                  report_mismatch("index_valid", got.index_valid, want.index_valid);
               if (got.pixel_lit !== want.pixel_lit)
                  report_mismatch("pixel_lit", got.pixel_lit, want.pixel_lit);
               if (got.from_palette !== want.from_palette)
                  report_mismatch("from_palette", got.from_palette, want.from_palette);
               if (got.color_value !== want.color_value)
                  report_mismatch("color_value", got.color_value, want.color_value);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_CARPET_DEPTH:    shadow_cfg.carpet_depth    = csr_ch.data[DEPTH_W-1:0];
               REG_INVERT_PATTERN:  shadow_cfg.invert_pattern  = csr_ch.data[0];
               REG_COLOR_SHIFT:     shadow_cfg.color_shift     = csr_ch.data[COLOR_W-1:0];
               REG_PANEL_REVERSE:   shadow_cfg.panel_reverse   = csr_ch.data[0];
               REG_PANEL_ROTATIONS: shadow_cfg.panel_rotations = csr_ch.data[ROTS_W-1:0];
               REG_PANEL_COUNT:     shadow_cfg.panel_count     = csr_ch.data[COUNT_W-1:0];
               REG_PALETTE_SIZE:    shadow_cfg.palette_size    = csr_ch.data[PAL_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.mode == MODE_TICK)
               color_phase = color_phase + shadow_cfg.color_shift;
            else
               expected_words.push_back(render_pixel(req_ch.pixel_x, req_ch.pixel_y));
         end
      end
      pending_cnt <= expected_words.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the carpet pixel renderer. Runs a short directed
// set of pixel and tick words, then random words under a series of register
// settings (extremes, out-of-range values, random), with bursty requests,
// patterned response stalls and one long response hold-off. The checker
// beside the block predicts and compares every response word.
// ---------------------------------------------------------------------------
module tb;
   import cpr_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int WORDS_PER_PHASE = 85;
   localparam int RANDOM_PHASES   = 7;
   localparam int DRAIN_CYCLES    = 12;
   localparam int LONG_HOLD       = 300;
   localparam int HOLD_AFTER      = 200;
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;

   logic clock;
   logic reset;
   int   pending_cnt;
   int   fail_count;
   int   cycle_count;
   int   words_sent = 0;
   int   burst_left = 0;
   int   active_cols = PANEL_SIDE;
   bit   hold_done = 1'b0;

   cpr_req_if req_ch();
   cpr_rsp_if rsp_ch();
   cpr_csr_if csr_ch();

   carpet_pixel_render_panel_map dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cpr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .pending_cnt (pending_cnt),
      .fail_count  (fail_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic load_settings(input int depth, input int inv, input int shift,
                                input int rev, input int rots, input int count,
                                input int pal);
      int cols;
      write_reg(REG_CARPET_DEPTH, depth);
      write_reg(REG_INVERT_PATTERN, inv);
      write_reg(REG_COLOR_SHIFT, shift);
      write_reg(REG_PANEL_REVERSE, rev);
      write_reg(REG_PANEL_ROTATIONS, rots);
      write_reg(REG_PANEL_COUNT, count);
      write_reg(REG_PALETTE_SIZE, pal);
      csr_ch.valid <= 1'b0;
      cols = count & 7;
      if (cols == 0) cols = 1;
      if (cols > MAX_PANELS) cols = MAX_PANELS;
      active_cols = cols * PANEL_SIDE;
   endtask

   task automatic offer_word(input logic mode, input int x, input int y);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= mode;
      req_ch.pixel_x <= X_W'(x);
      req_ch.pixel_y <= Y_W'(y);
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   task automatic drain(input int extra);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_cnt != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic random_words(input int n);
      int x;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            offer_word(MODE_TICK, $urandom_range(0, 63), $urandom_range(0, 15));
         end else begin
            x = $urandom_range(0, 1) ? $urandom_range(0, active_cols - 1)
                                     : $urandom_range(0, 63);
            offer_word(MODE_PIXEL, x, $urandom_range(0, 15));
         end
      end
   endtask

   // response side: stall pattern of its own, plus one long hold-off
   initial begin
      int style;
      int run_len;
      rsp_ch.ready <= 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         run_len = $urandom_range(16, 96);
         for (int step = 0; step < run_len; step++) begin
            @(posedge clock);
            if (!hold_done && words_sent >= HOLD_AFTER) begin
               hold_done = 1'b1;
               rsp_ch.ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (style)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= (step % 4 != 3);
            endcase
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int pal;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.mode    <= MODE_PIXEL;
      req_ch.pixel_x <= '0;
      req_ch.pixel_y <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= '0;
      csr_ch.data    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one panel, depth 4, hue output
      offer_word(MODE_PIXEL, 0, 0);
      offer_word(MODE_PIXEL, 15, 15);
      offer_word(MODE_PIXEL, 5, 5);
      offer_word(MODE_PIXEL, 1, 1);
      offer_word(MODE_PIXEL, 6, 6);
      offer_word(MODE_PIXEL, 10, 4);
      offer_word(MODE_PIXEL, 16, 0);
      offer_word(MODE_PIXEL, 63, 15);
      offer_word(MODE_TICK, 0, 0);
      offer_word(MODE_PIXEL, 9, 9);
      offer_word(MODE_TICK, 63, 15);
      offer_word(MODE_PIXEL, 7, 3);
      drain(DRAIN_CYCLES);

      // three panels, rotations 90/180/270, reversed order, inverted, small palette
      write_reg(REG_UNUSED, 9'h1FF);
      load_settings(2, 1, 200, 1, 6'b111001, 3, 7);
      offer_word(MODE_PIXEL, 0, 0);
      offer_word(MODE_PIXEL, 15, 1);
      offer_word(MODE_PIXEL, 16, 0);
      offer_word(MODE_PIXEL, 21, 6);
      offer_word(MODE_PIXEL, 17, 1);
      offer_word(MODE_PIXEL, 31, 15);
      offer_word(MODE_PIXEL, 40, 8);
      offer_word(MODE_PIXEL, 47, 15);
      offer_word(MODE_PIXEL, 48, 0);
      offer_word(MODE_TICK, 0, 0);
      offer_word(MODE_PIXEL, 24, 10);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain(DRAIN_CYCLES);
         case (p)
            0: load_settings(0, 0, 0, 0, 0, 0, 0);
            1: load_settings(7, 1, 255, 1, 63, 7, 511);
            2: load_settings(6, 0, 1, 1, 27, 4, 256);
            3: load_settings(1, 1, 128, 0, 36, 2, 1);
            default: begin
               pal = $urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(1, 12);
               load_settings($urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom_range(0, 511), $urandom_range(0, 511), pal);
            end
         endcase
         random_words(WORDS_PER_PHASE);
      end

      drain(DRAIN_CYCLES);
      @(negedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
